// File: rtl/kpt_pkg.sv
// kpt_pkg: shared constants, types and command/status bundles for the keyed point table.
// No dependencies; used by every other file of the block except kpt_ram.
package kpt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 64;
    localparam int PKEY_W      = 64;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W       = 1 + KEY_BITS + WORD_W;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_MODIFY = 2'd3
    } t_op;

    typedef struct packed {
        logic                kind;
        logic [KEY_BITS-1:0] key;
        logic [WORD_W-1:0]   word;
    } t_ent;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
        logic shift;
    } t_cmd;

    typedef struct packed {
        logic             scan_done;
        logic             shift_done;
        logic             del_go;
        logic [CNT_W-1:0] cnt;
    } t_sts;

endpackage

// File: rtl/kpt_ifs.sv
// kpt_ifs: request and response channel interfaces (valid/ready plus payload).
// Depends on kpt_pkg for field widths.
interface kpt_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic                        point_kind;
    logic [kpt_pkg::PKEY_W-1:0]  point_key;
    logic [kpt_pkg::WORD_W-1:0]  write_word;

    modport source (output valid, opcode, point_kind, point_key, write_word, input ready);
    modport sink   (input valid, opcode, point_kind, point_key, write_word, output ready);
endinterface

interface kpt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [kpt_pkg::WORD_W-1:0]  read_word;
    logic                        read_valid;

    modport source (output valid, status, read_word, read_valid, input ready);
    modport sink   (input valid, status, read_word, read_valid, output ready);
endinterface

// File: rtl/kpt_ram.sv
// kpt_ram: generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
module kpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/kpt_ctrl.sv
// kpt_ctrl: request sequencer (idle, scan, execute, compact) and response valid flag.
// Depends on kpt_pkg; drives kpt_dp through t_cmd and reads back t_sts.
module kpt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    input  kpt_pkg::t_sts i_sts,
    output kpt_pkg::t_cmd o_cmd
);
    import kpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_SHIFT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_vld, n_rsp_vld;
    logic   rsp_free;

    assign rsp_free = !r_rsp_vld || i_rsp_ready;

    always_comb begin
        n_state   = r_state;
        n_rsp_vld = r_rsp_vld && !i_rsp_ready;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (rsp_free) begin
                    o_cmd.exec = 1'b1;
                    n_rsp_vld  = 1'b1;
                    n_state    = i_sts.del_go ? S_SHIFT : S_IDLE;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_vld;
endmodule

// File: rtl/kpt_dp.sv
// kpt_dp: entry RAM, request registers, scan/compaction pointers, entry count, response word.
// Depends on kpt_pkg and kpt_ram; steered by kpt_ctrl via t_cmd.
module kpt_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kpt_pkg::t_cmd               i_cmd,
    output kpt_pkg::t_sts               o_sts,
    input  logic [1:0]                  i_opcode,
    input  logic                        i_point_kind,
    input  logic [kpt_pkg::PKEY_W-1:0]  i_point_key,
    input  logic [kpt_pkg::WORD_W-1:0]  i_write_word,
    output logic                        o_status,
    output logic [kpt_pkg::WORD_W-1:0]  o_read_word,
    output logic                        o_read_valid
);
    import kpt_pkg::*;

    t_op                 r_op;
    logic                r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic [WORD_W-1:0]   r_word;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_idx;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_found;
    logic [IDX_W-1:0]    r_slot;
    logic                r_status;
    logic [WORD_W-1:0]   r_rword;
    logic                r_rvalid;

    logic [ENT_W-1:0]    rd_data;
    t_ent                ent;
    logic                hit, more, issue, scan_done, shift_done;
    logic                ins_ok, op_ok, del_go;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [ENT_W-1:0]    wdata;

    always_comb begin
        ent        = t_ent'(rd_data);
        hit        = i_cmd.scan && r_cmp_vld && (ent.kind == r_kind) && (ent.key == r_key);
        more       = (r_idx < r_cnt);
        issue      = (i_cmd.scan && more && !hit) || (i_cmd.shift && more);
        scan_done  = hit || (!r_cmp_vld && !more);
        shift_done = !r_cmp_vld && !more;
        ins_ok     = (r_op == OP_INSERT) && !r_found && (r_cnt < CNT_W'(TABLE_DEPTH));
        op_ok      = (r_op == OP_INSERT) ? ins_ok : r_found;
        del_go     = (r_op == OP_DELETE) && r_found;
        we         = (i_cmd.exec && (ins_ok || ((r_op == OP_MODIFY) && r_found)))
                     || (i_cmd.shift && r_cmp_vld);
        priority if (i_cmd.shift) begin
            waddr = r_cmp_idx - 1'b1;
            wdata = rd_data;
        end else if (r_op == OP_INSERT) begin
            waddr = r_cnt[IDX_W-1:0];
            wdata = {r_kind, r_key, r_word};
        end else begin
            waddr = r_slot;
            wdata = {r_kind, r_key, r_word};
        end
    end

    kpt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan || i_cmd.shift) begin
                r_cmp_vld <= issue;
            end else if (i_cmd.exec) begin
                r_cmp_vld <= 1'b0;
            end
            if (i_cmd.exec && ins_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.shift && shift_done) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_opcode);
            r_kind  <= i_point_kind;
            r_key   <= i_point_key[KEY_BITS-1:0];
            r_word  <= i_write_word;
            r_idx   <= '0;
            r_found <= 1'b0;
        end
        if (issue) begin
            r_cmp_idx <= r_idx[IDX_W-1:0];
            r_idx     <= r_idx + 1'b1;
        end
        if (hit) begin
            r_found <= 1'b1;
            r_slot  <= r_cmp_idx;
        end
        if (i_cmd.exec) begin
            r_status <= !op_ok;
            r_rvalid <= (r_op == OP_QUERY) && r_found;
            r_rword  <= ((r_op == OP_QUERY) && r_found) ? ent.word : '0;
            if (del_go) begin
                r_idx <= CNT_W'(r_slot) + 1'b1;
            end
        end
    end

    assign o_sts.scan_done  = scan_done;
    assign o_sts.shift_done = shift_done;
    assign o_sts.del_go     = del_go;
    assign o_sts.cnt        = r_cnt;

    assign o_status     = r_status;
    assign o_read_word  = r_rword;
    assign o_read_valid = r_rvalid;
endmodule

// File: rtl/keyed_point_table.sv
// keyed_point_table: top level; joins kpt_ctrl and kpt_dp to the request/response channels.
// Depends on kpt_pkg, kpt_ifs, kpt_ctrl, kpt_dp (and kpt_ram beneath it).
//
//  channel  dir  modport          payload
//  i_req    in   kpt_req_if.sink  opcode, point_kind, point_key, write_word
//  o_rsp    out  kpt_rsp_if.source status, read_word, read_valid
//
// Scan reads one entry a cycle until a hit or the end of the held entries; a delete
// then compacts the table, moving each entry above the removed slot down one place.
// Synchronous reset empties the table at once (count to zero); no clearing pass.
// A waiting response leaves acceptance open; a stalled response holds the next
// request in its execute step until the output register frees.
module keyed_point_table (
    input logic      i_clk,
    input logic      i_rst_n,
    kpt_req_if.sink  i_req,
    kpt_rsp_if.source o_rsp
);
    import kpt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    kpt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_req.opcode),
        .i_point_kind (i_req.point_kind),
        .i_point_key  (i_req.point_key),
        .i_write_word (i_req.write_word),
        .o_status     (o_rsp.status),
        .o_read_word  (o_rsp.read_word),
        .o_read_valid (o_rsp.read_valid)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request port ready straight after an accepted word");

    a_read_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.read_valid) |-> !o_rsp.status)
        else $error("query answer flagged with an error status");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.cnt <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.exec, cmd.shift}))
        else $error("more than one datapath command at once");
endmodule

// File: bench/tb_keyed_point_table.sv
`timescale 1ns / 1ps
// tb_keyed_point_table: self-checking bench for the keyed point table. A directed table, a
// fill, then random insert/delete/query/modify words; replies are scored against given answers
// or an in-bench table. Depends on kpt_pkg, kpt_ifs and the keyed_point_table RTL.
module tb_keyed_point_table;
    import kpt_pkg::*;

    localparam int POOL_SIZE    = 80;
    localparam int FILL_COUNT   = 70;
    localparam int ITEM_TARGET  = 1350;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 500;
    localparam int REPORT_MAX   = 10;

    localparam logic DIGITAL = 1'b0;
    localparam logic ANALOG  = 1'b1;
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_ERR  = 1'b1;

    localparam logic [PKEY_W-1:0] NAME_ONES = '1;
    localparam logic [PKEY_W-1:0] NAME_TOP  = 64'h8000_0000_0000_0000;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_BEAT
    } t_sink_mode;

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] rword;
        logic              rvalid;
    } t_reply;

    typedef struct packed {
        t_op               op;
        logic              kind;
        logic [PKEY_W-1:0] key;
        logic [WORD_W-1:0] word;
        logic              given;
        t_reply            reply;
    } t_request;

    localparam int N_DIRECTED = 25;
    localparam t_request DIRECTED [N_DIRECTED] = '{
        '{OP_QUERY,  DIGITAL, 64'h0,     32'hDEAD_BEEF, 1'b1, '{ST_ERR, 32'h0, 1'b0}},
        '{OP_DELETE, DIGITAL, 64'h0,     32'hDEAD_BEEF, 1'b1, '{ST_ERR, 32'h0, 1'b0}},
        '{OP_MODIFY, ANALOG,  NAME_ONES, 32'h0000_0001, 1'b1, '{ST_ERR, 32'h0, 1'b0}},
        '{OP_INSERT, DIGITAL, 64'h0,     32'h0000_0000, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_INSERT, DIGITAL, 64'h0,     32'h0000_0005, 1'b1, '{ST_ERR, 32'h0, 1'b0}},
        '{OP_INSERT, ANALOG,  64'h0,     32'hFFFF_FFFF, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_QUERY,  DIGITAL, 64'h0,     32'hFFFF_FFFF, 1'b1, '{ST_OK,  32'h0, 1'b1}},
        '{OP_QUERY,  ANALOG,  64'h0,     32'h0000_0000, 1'b1, '{ST_OK,  32'hFFFF_FFFF, 1'b1}},
        '{OP_INSERT, ANALOG,  NAME_ONES, 32'h8000_0000, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_INSERT, DIGITAL, NAME_ONES, 32'h7FFF_FFFF, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_QUERY,  ANALOG,  NAME_ONES, 32'h5555_5555, 1'b1, '{ST_OK,  32'h8000_0000, 1'b1}},
        '{OP_MODIFY, DIGITAL, 64'h0,     32'hA5A5_5A5A, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_QUERY,  DIGITAL, 64'h0,     32'h0000_0000, 1'b1, '{ST_OK,  32'hA5A5_5A5A, 1'b1}},
        '{OP_QUERY,  DIGITAL, 64'h1,     32'h0000_0000, 1'b1, '{ST_ERR, 32'h0, 1'b0}},
        '{OP_DELETE, DIGITAL, 64'h0,     32'hDEAD_BEEF, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_QUERY,  DIGITAL, 64'h0,     32'h0000_0000, 1'b1, '{ST_ERR, 32'h0, 1'b0}},
        '{OP_QUERY,  ANALOG,  64'h0,     32'h0000_0000, 1'b0, '0},
        '{OP_QUERY,  DIGITAL, NAME_ONES, 32'h0000_0000, 1'b0, '0},
        '{OP_DELETE, DIGITAL, NAME_ONES, 32'h0000_0000, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_MODIFY, ANALOG,  64'h0,     32'h1234_5678, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_DELETE, ANALOG,  64'h0,     32'h0000_0000, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_QUERY,  ANALOG,  NAME_ONES, 32'h0000_0000, 1'b0, '0},
        '{OP_DELETE, ANALOG,  NAME_ONES, 32'hFFFF_FFFF, 1'b1, '{ST_OK,  32'h0, 1'b0}},
        '{OP_QUERY,  ANALOG,  NAME_ONES, 32'h0000_0000, 1'b1, '{ST_ERR, 32'h0, 1'b0}},
        '{OP_INSERT, ANALOG,  NAME_TOP,  32'h0000_0001, 1'b1, '{ST_OK,  32'h0, 1'b0}}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kpt_req_if req_ch ();
    kpt_rsp_if rsp_ch ();

    keyed_point_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench copy of the point table
    logic                tbl_kind [TABLE_DEPTH];
    logic [KEY_BITS-1:0] tbl_key  [TABLE_DEPTH];
    logic [WORD_W-1:0]   tbl_word [TABLE_DEPTH];
    int                  tbl_used = 0;

    logic              pool_kind [POOL_SIZE];
    logic [PKEY_W-1:0] pool_key  [POOL_SIZE];

    t_request stimulus [$];
    t_reply   pending_replies [$];
    int       fault_count  = 0;
    int       stall_cycles = 0;
    t_reply   got_reply;
    t_reply   want_reply;

    function automatic t_reply point_table_step(t_request r);
        t_reply              rep;
        logic [KEY_BITS-1:0] name;
        int                  slot;
        int                  i;
        rep  = '{status: ST_ERR, rword: '0, rvalid: 1'b0};
        name = r.key[KEY_BITS-1:0];
        slot = -1;
        for (i = 0; i < tbl_used; i++) begin
            if (slot < 0 && tbl_kind[i] == r.kind && tbl_key[i] == name) slot = i;
        end
        case (r.op)
            OP_INSERT: begin
                if (slot < 0 && tbl_used < TABLE_DEPTH) begin
                    tbl_kind[tbl_used] = r.kind;
                    tbl_key[tbl_used]  = name;
                    tbl_word[tbl_used] = r.word;
                    tbl_used++;
                    rep.status = ST_OK;
                end
            end
            OP_DELETE: begin
                if (slot >= 0) begin
                    for (i = slot; i < tbl_used - 1; i++) begin
                        tbl_kind[i] = tbl_kind[i + 1];
                        tbl_key[i]  = tbl_key[i + 1];
                        tbl_word[i] = tbl_word[i + 1];
                    end
                    tbl_used--;
                    rep.status = ST_OK;
                end
            end
            OP_QUERY: begin
                if (slot >= 0) begin
                    rep.status = ST_OK;
                    rep.rword  = tbl_word[slot];
                    rep.rvalid = 1'b1;
                end
            end
            default: begin
                if (slot >= 0) begin
                    tbl_word[slot] = r.word;
                    rep.status     = ST_OK;
                end
            end
        endcase
        return rep;
    endfunction

    function automatic logic [PKEY_W-1:0] random_name();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return $urandom;
    endfunction

    function automatic void queue_request(t_op op, logic kind, logic [PKEY_W-1:0] key,
                                          logic [WORD_W-1:0] word);
        t_request r;
        r = '{op: op, kind: kind, key: key, word: word, given: 1'b0, reply: '0};
        stimulus.push_back(r);
    endfunction

    function automatic void log_fault(string what, t_reply want, t_reply got);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("%0t %s: want status %0b word %h valid %0b, got status %0b word %h valid %0b",
                     $time, what, want.status, want.rword, want.rvalid,
                     got.status, got.rword, got.rvalid);
    endfunction

    // reply scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got_reply = '{status: rsp_ch.status, rword: rsp_ch.read_word,
                          rvalid: rsp_ch.read_valid};
            if (pending_replies.size() == 0) begin
                log_fault("reply with none pending", '0, got_reply);
            end else begin
                want_reply = pending_replies.pop_front();
                if (got_reply.status !== want_reply.status ||
                    got_reply.rword !== want_reply.rword ||
                    got_reply.rvalid !== want_reply.rvalid)
                    log_fault("reply mismatch", want_reply, got_reply);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : sink_side
        t_sink_mode mode;
        int         span;
        int         tick;
        int         seen;
        bit         held;
        rsp_ch.ready <= 1'b0;
        tick = 0;
        seen = 0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            // long hold-off so the block backs up and stalls its input
            if (!held && seen >= HOLD_AFTER) begin
                @(posedge i_clk);
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end
            mode = t_sink_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                if (rsp_ch.valid && rsp_ch.ready) seen++;
                tick++;
                case (mode)
                    SINK_OPEN:   rsp_ch.ready <= 1'b1;
                    SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:     rsp_ch.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    initial begin : source_side
        t_request r;
        t_reply   predicted;
        t_op      op;
        int       idx;
        int       burst;
        int       gap;
        int       pick;
        int       slot;
        int       phase_len;
        int       ins_lim;
        int       del_lim;
        int       qry_lim;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_INSERT;
        req_ch.point_kind <= DIGITAL;
        req_ch.point_key  <= '0;
        req_ch.write_word <= '0;

        // name pool: each name under both kinds, every other pair one bit off its neighbour
        for (idx = 0; idx < POOL_SIZE; idx++) begin
            if (idx % 4 == 0)
                pool_key[idx] = random_name();
            else if (idx % 4 == 2)
                pool_key[idx] = pool_key[idx - 2] ^ (64'd1 << $urandom_range(0, 63));
            else
                pool_key[idx] = pool_key[idx - 1];
            pool_kind[idx] = idx[0];
        end

        for (idx = 0; idx < N_DIRECTED; idx++) stimulus.push_back(DIRECTED[idx]);

        // fill past the top, then probe hits and misses on the full table
        for (idx = 0; idx < FILL_COUNT; idx++)
            queue_request(OP_INSERT, pool_kind[idx], pool_key[idx], random_word());
        queue_request(OP_INSERT, pool_kind[0], pool_key[0], random_word());
        for (idx = 50; idx < POOL_SIZE; idx++)
            queue_request(OP_QUERY, pool_kind[idx], pool_key[idx], random_word());

        while (stimulus.size() < ITEM_TARGET) begin
            case ($urandom_range(0, 3))
                0: begin
                    ins_lim = 30; del_lim = 55; qry_lim = 80;
                end
                1: begin
                    ins_lim = 60; del_lim = 70; qry_lim = 90;
                end
                2: begin
                    ins_lim = 15; del_lim = 65; qry_lim = 85;
                end
                default: begin
                    ins_lim = 20; del_lim = 35; qry_lim = 70;
                end
            endcase
            phase_len = $urandom_range(60, 150);
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                op = (pick < ins_lim) ? OP_INSERT :
                     (pick < del_lim) ? OP_DELETE :
                     (pick < qry_lim) ? OP_QUERY : OP_MODIFY;
                slot = $urandom_range(0, POOL_SIZE - 1);
                if (op != OP_INSERT && $urandom_range(0, 9) == 0)
                    queue_request(op, 1'($urandom_range(0, 1)), random_name(), random_word());
                else
                    queue_request(op, pool_kind[slot], pool_key[slot], random_word());
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idx = 0;
        while (idx < stimulus.size()) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            while (burst > 0 && idx < stimulus.size()) begin
                r = stimulus[idx];
                req_ch.valid      <= 1'b1;
                req_ch.opcode     <= r.op;
                req_ch.point_kind <= r.kind;
                req_ch.point_key  <= r.key;
                req_ch.write_word <= r.word;
                do @(posedge i_clk); while (!req_ch.ready);
                predicted = point_table_step(r);
                pending_replies.push_back(r.given ? r.reply : predicted);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
